// File: hw/rtl/vertex_perspective_transform_assert.svh
// Assertion macros used by the checker module of the vertex transform.
`ifndef VERTEX_PERSPECTIVE_TRANSFORM_ASSERT_SVH
`define VERTEX_PERSPECTIVE_TRANSFORM_ASSERT_SVH

// Same-cycle implication, switched off while reset is asserted.
`define VPT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is asserted.
`define VPT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset.
`define VPT_ASSERT_ALWAYS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/vpt_pkg.sv
package vpt_pkg;

    // Default fixed-point format of the vertex and the coefficients.
    localparam int FRAC_BITS_DEF   = 12;
    localparam int COEFF_WIDTH_DEF = 16;

    // Fixed widths of the stream words and the register file.
    localparam int DATA_W     = 32;
    localparam int REG_W      = 64;
    localparam int ADDR_W     = 6;
    localparam int HALF_W     = 16;
    localparam int COEF_PITCH = 16;
    localparam int IN_W       = 3 * DATA_W;
    localparam int USER_W     = 2;

    // Register indexes; each register sits at byte address 8 * index.
    typedef enum logic [2:0] {
        REG_ROW0     = 3'd0,
        REG_ROW1     = 3'd1,
        REG_ROW2     = 3'd2,
        REG_ROW3     = 3'd3,
        REG_DEPTH    = 3'd4,
        REG_HALF_W   = 3'd5,
        REG_HALF_H   = 3'd6,
        REG_VIEWPORT = 3'd7
    } t_reg_idx;

endpackage

// File: hw/rtl/vertex_perspective_transform.sv
// Channel     Direction  Word
// s_axis_*    in         one vertex: x, y, z
// m_axis_*    out        one transformed vertex plus w_was_zero and clipped flags
// APB         in/out     matrix rows, depth offset, half sizes, viewport mode
//
// Every vertex passes 41 pipeline registers: capture and the matrix multiply and sums
// take four, the divider set-up one and one per quotient bit (33), then quotient, viewport
// and saturation three. One vertex enters per cycle while the output is not stalled.
// Reset is synchronous, clears the valid bits and loads the identity matrix. A stalled
// output freezes the whole pipeline; nothing is lost or repeated.
module vertex_perspective_transform #(
    parameter int FRAC_BITS   = vpt_pkg::FRAC_BITS_DEF,
    parameter int COEFF_WIDTH = vpt_pkg::COEFF_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [vpt_pkg::ADDR_W-1:0]  paddr,
    input  logic [vpt_pkg::REG_W-1:0]   pwdata,
    output logic [vpt_pkg::REG_W-1:0]   prdata,
    output logic                        pready,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // Fields from bit 0 up: in_x, in_y, in_z.
    input  logic [vpt_pkg::IN_W-1:0]    s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // Fields from bit 0 up: out_x, out_y, out_z.
    output logic [vpt_pkg::IN_W-1:0]    m_axis_tdata,
    // Fields from bit 0 up: w_was_zero, clipped.
    output logic [vpt_pkg::USER_W-1:0]  m_axis_tuser
);
    import vpt_pkg::*;

    localparam int ZW     = DATA_W + 1;
    localparam int PROD_W = ZW + COEFF_WIDTH;
    localparam int ACC_W  = PROD_W + 2;
    localparam int QB     = DATA_W + 1;
    localparam int MAG_W  = QB;
    localparam int RES_W  = MAG_W + 1;
    localparam int NUM_W  = ACC_W + FRAC_BITS;
    localparam int VP_W   = RES_W + 1;
    localparam int VPP_W  = VP_W + HALF_W + 1;
    localparam logic [MAG_W-1:0] LIM = {1'b1, {DATA_W{1'b0}}};

    // Configuration registers.
    logic [REG_W-1:0]   r_row [4];
    logic [DATA_W-1:0]  r_depth;
    logic [HALF_W-1:0]  r_hw;
    logic [HALF_W-1:0]  r_hh;
    logic               r_vp;
    logic               w_cfg_wr;
    t_reg_idx           w_idx;

    assign pready   = 1'b1;
    assign w_idx    = t_reg_idx'(paddr[5:3]);
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row[0] <= 64'h0000_0000_0000_1000;
            r_row[1] <= 64'h0000_0000_1000_0000;
            r_row[2] <= 64'h0000_1000_0000_0000;
            r_row[3] <= 64'h1000_0000_0000_0000;
            r_depth  <= '0;
            r_hw     <= HALF_W'(1280);
            r_hh     <= HALF_W'(720);
            r_vp     <= 1'b0;
        end else if (w_cfg_wr) begin
            case (w_idx)
                REG_ROW0:     r_row[0] <= pwdata;
                REG_ROW1:     r_row[1] <= pwdata;
                REG_ROW2:     r_row[2] <= pwdata;
                REG_ROW3:     r_row[3] <= pwdata;
                REG_DEPTH:    r_depth  <= pwdata[DATA_W-1:0];
                REG_HALF_W:   r_hw     <= pwdata[HALF_W-1:0];
                REG_HALF_H:   r_hh     <= pwdata[HALF_W-1:0];
                REG_VIEWPORT: r_vp     <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (w_idx)
            REG_ROW0:     prdata = r_row[0];
            REG_ROW1:     prdata = r_row[1];
            REG_ROW2:     prdata = r_row[2];
            REG_ROW3:     prdata = r_row[3];
            REG_DEPTH:    prdata = REG_W'(r_depth);
            REG_HALF_W:   prdata = REG_W'(r_hw);
            REG_HALF_H:   prdata = REG_W'(r_hh);
            REG_VIEWPORT: prdata = REG_W'(r_vp);
            default:      prdata = '0;
        endcase
    end

    // Coefficients taken out of the row registers.
    logic signed [COEFF_WIDTH-1:0] w_coef [4][4];
    always_comb begin
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                w_coef[r][c] = r_row[r][COEF_PITCH*c +: COEFF_WIDTH];
            end
        end
    end

    // The whole pipeline moves when the output register is free or being taken.
    logic r_o_vld;
    logic w_en;
    assign w_en          = !r_o_vld || m_axis_tready;
    assign s_axis_tready = w_en;

    // Stage 0: input capture, depth offset added to z.
    logic                    r_s0_vld;
    logic signed [ZW-1:0]    r_v [3];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_v[0] <= ZW'($signed(s_axis_tdata[DATA_W-1:0]));
            r_v[1] <= ZW'($signed(s_axis_tdata[2*DATA_W-1:DATA_W]));
            r_v[2] <= ZW'($signed(s_axis_tdata[3*DATA_W-1:2*DATA_W]))
                    + ZW'($signed(r_depth));
        end
    end

    // Stage 1: the twelve vertex products.
    logic                        r_s1_vld;
    logic signed [PROD_W-1:0]    r_prod [3][4];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 4; c++) begin
                    r_prod[r][c] <= PROD_W'(r_v[r]) * PROD_W'(w_coef[r][c]);
                end
            end
        end
    end

    // Stage 2: pairwise sums, translation term aligned to the product scale.
    logic                        r_s2_vld;
    logic signed [ACC_W-1:0]     r_psa [4];
    logic signed [ACC_W-1:0]     r_psb [4];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int c = 0; c < 4; c++) begin
                r_psa[c] <= ACC_W'(r_prod[0][c]) + ACC_W'(r_prod[1][c]);
                r_psb[c] <= ACC_W'(r_prod[2][c]) + (ACC_W'(w_coef[3][c]) <<< FRAC_BITS);
            end
        end
    end

    // Stage 3: final sums x, y, z and w.
    logic                        r_s3_vld;
    logic signed [ACC_W-1:0]     r_acc [4];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int c = 0; c < 4; c++) begin
                r_acc[c] <= r_psa[c] + r_psb[c];
            end
        end
    end

    // Divider pipeline: entry 0 is the set-up stage, entry i+1 holds i+1 quotient bits.
    logic                      r_d_vld  [QB+1];
    logic [ACC_W-1:0]          r_d_md   [QB+1];
    logic                      r_d_wz   [QB+1];
    logic [ACC_W-1:0]          r_d_rem  [QB+1][3];
    logic [QB-1:0]             r_d_q    [QB+1][3];
    logic [QB-1:0]             r_d_n    [QB+1][3];
    logic                      r_d_neg  [QB+1][3];
    logic                      r_d_ovf  [QB+1][3];
    logic signed [RES_W-1:0]   r_d_resc [QB+1][3];

    // Set-up: magnitudes, signs, overflow test and the undivided result.
    logic [ACC_W-1:0]         w_md;
    logic [ACC_W-1:0]         w_ma   [3];
    logic [NUM_W-1:0]         w_num  [3];
    logic [ACC_W-1:0]         w_sh   [3];
    logic [MAG_W-1:0]         w_rmag [3];
    always_comb begin
        w_md = r_acc[3][ACC_W-1] ? ACC_W'(-r_acc[3]) : ACC_W'(r_acc[3]);
        for (int c = 0; c < 3; c++) begin
            w_ma[c]   = r_acc[c][ACC_W-1] ? ACC_W'(-r_acc[c]) : ACC_W'(r_acc[c]);
            w_num[c]  = NUM_W'(w_ma[c]) << FRAC_BITS;
            w_sh[c]   = w_ma[c] >> FRAC_BITS;
            w_rmag[c] = (w_sh[c] > ACC_W'(LIM)) ? LIM : w_sh[c][MAG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d_md[0] <= w_md;
            r_d_wz[0] <= (r_acc[3] == '0);
            for (int c = 0; c < 3; c++) begin
                r_d_rem[0][c]  <= ACC_W'(w_num[c] >> QB);
                r_d_q[0][c]    <= '0;
                r_d_n[0][c]    <= w_num[c][QB-1:0];
                r_d_neg[0][c]  <= r_acc[c][ACC_W-1] ^ r_acc[3][ACC_W-1];
                r_d_ovf[0][c]  <= (w_num[c] >> QB) >= NUM_W'(w_md);
                r_d_resc[0][c] <= r_acc[c][ACC_W-1] ? -RES_W'(w_rmag[c]) : RES_W'(w_rmag[c]);
            end
        end
    end

    // One restoring step per stage, most significant quotient bit first.
    for (genvar i = 0; i < QB; i++) begin : g_div
        logic [ACC_W:0]   w_t    [3];
        logic             w_take [3];
        always_comb begin
            for (int c = 0; c < 3; c++) begin
                w_t[c]    = {r_d_rem[i][c], r_d_n[i][c][QB-1-i]};
                w_take[c] = w_t[c] >= {1'b0, r_d_md[i]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_d_md[i+1] <= r_d_md[i];
                r_d_wz[i+1] <= r_d_wz[i];
                for (int c = 0; c < 3; c++) begin
                    r_d_rem[i+1][c]  <= w_take[c] ? ACC_W'(w_t[c] - {1'b0, r_d_md[i]})
                                                  : ACC_W'(w_t[c]);
                    r_d_q[i+1][c]    <= {r_d_q[i][c][QB-2:0], w_take[c]};
                    r_d_n[i+1][c]    <= r_d_n[i][c];
                    r_d_neg[i+1][c]  <= r_d_neg[i][c];
                    r_d_ovf[i+1][c]  <= r_d_ovf[i][c];
                    r_d_resc[i+1][c] <= r_d_resc[i][c];
                end
            end
        end
    end

    // Stage 5: quotient limited and signed, or the undivided value when w is zero.
    logic                     r_s5_vld;
    logic                     r_s5_wz;
    logic signed [RES_W-1:0]  r_res [3];
    logic [MAG_W-1:0]         w_qmag [3];
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_qmag[c] = (r_d_ovf[QB][c] || (r_d_q[QB][c] > LIM)) ? LIM : r_d_q[QB][c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s5_wz <= r_d_wz[QB];
            for (int c = 0; c < 3; c++) begin
                if (r_d_wz[QB]) begin
                    r_res[c] <= r_d_resc[QB][c];
                end else begin
                    r_res[c] <= r_d_neg[QB][c] ? -RES_W'(w_qmag[c]) : RES_W'(w_qmag[c]);
                end
            end
        end
    end

    // Stage 6: viewport mapping of x and y when the viewport mode is on; z passes through.
    logic                     r_s6_vld;
    logic                     r_s6_wz;
    logic signed [VPP_W-1:0]  r_vpx [3];
    logic signed [VP_W-1:0]   w_off [2];
    logic [HALF_W-1:0]        w_half [2];
    always_comb begin
        w_half[0] = r_hw;
        w_half[1] = r_hh;
        for (int c = 0; c < 2; c++) begin
            w_off[c] = VP_W'(r_res[c]) + VP_W'(1 << FRAC_BITS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s6_wz  <= r_s5_wz;
            r_vpx[2] <= VPP_W'(r_res[2]);
            for (int c = 0; c < 2; c++) begin
                if (r_vp) begin
                    r_vpx[c] <= VPP_W'(w_off[c]) * VPP_W'($signed({1'b0, w_half[c]}));
                end else begin
                    r_vpx[c] <= VPP_W'(r_res[c]);
                end
            end
        end
    end

    // Stage 7: saturation to 32 bits into the output register.
    logic [DATA_W-1:0]  r_out [3];
    logic               r_o_wz;
    logic               r_o_clip;
    logic [DATA_W-1:0]  w_sat  [3];
    logic [2:0]         w_clip;
    localparam logic signed [VPP_W-1:0] SMAX = VPP_W'({1'b0, {(DATA_W-1){1'b1}}});
    localparam logic signed [VPP_W-1:0] SMIN = -VPP_W'({1'b1, {(DATA_W-1){1'b0}}});
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            if (r_vpx[c] > SMAX) begin
                w_sat[c]  = {1'b0, {(DATA_W-1){1'b1}}};
                w_clip[c] = 1'b1;
            end else if (r_vpx[c] < SMIN) begin
                w_sat[c]  = {1'b1, {(DATA_W-1){1'b0}}};
                w_clip[c] = 1'b1;
            end else begin
                w_sat[c]  = r_vpx[c][DATA_W-1:0];
                w_clip[c] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int c = 0; c < 3; c++) begin
                r_out[c] <= w_sat[c];
            end
            r_o_wz   <= r_s6_wz;
            r_o_clip <= |w_clip;
        end
    end

    // Valid bits travel with the words.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            for (int i = 0; i <= QB; i++) begin
                r_d_vld[i] <= 1'b0;
            end
            r_s5_vld <= 1'b0;
            r_s6_vld <= 1'b0;
            r_o_vld  <= 1'b0;
        end else if (w_en) begin
            r_s0_vld   <= s_axis_tvalid;
            r_s1_vld   <= r_s0_vld;
            r_s2_vld   <= r_s1_vld;
            r_s3_vld   <= r_s2_vld;
            r_d_vld[0] <= r_s3_vld;
            for (int i = 0; i < QB; i++) begin
                r_d_vld[i+1] <= r_d_vld[i];
            end
            r_s5_vld <= r_d_vld[QB];
            r_s6_vld <= r_s5_vld;
            r_o_vld  <= r_s6_vld;
        end
    end

    assign m_axis_tvalid = r_o_vld;
    assign m_axis_tdata  = {r_out[2], r_out[1], r_out[0]};
    assign m_axis_tuser  = {r_o_clip, r_o_wz};

endmodule

// File: hw/rtl/vpt_checker.sv
`include "vertex_perspective_transform_assert.svh"

module vpt_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        psel,
    input logic                        penable,
    input logic                        pwrite,
    input logic [vpt_pkg::ADDR_W-1:0]  paddr,
    input logic [vpt_pkg::REG_W-1:0]   pwdata,
    input logic [vpt_pkg::REG_W-1:0]   prdata,
    input logic                        pready,
    input logic                        s_axis_tvalid,
    input logic                        s_axis_tready,
    input logic [vpt_pkg::IN_W-1:0]    s_axis_tdata,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [vpt_pkg::IN_W-1:0]    m_axis_tdata,
    input logic [vpt_pkg::USER_W-1:0]  m_axis_tuser
);
    import vpt_pkg::*;

    // A held output word keeps its payload.
    `VPT_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
        "output word changed while stalled")

    // A stalled output stops the whole pipeline, so no vertex is taken.
    `VPT_ASSERT_IMP(a_stall_blocks_in, m_axis_tvalid && !m_axis_tready, !s_axis_tready,
        "input accepted while the output was stalled")

    // Nothing leaves the block in the cycle after reset.
    `VPT_ASSERT_ALWAYS(a_reset_empty, !i_rst_n, !m_axis_tvalid,
        "output valid right after reset")

    // A write to the viewport register is visible on read-back while the address stays.
    `VPT_ASSERT_NEXT(a_vp_readback,
        psel && penable && pwrite && pready && (paddr[5:3] == REG_VIEWPORT),
        ($past(paddr) != paddr) || (prdata[0] == $past(pwdata[0])),
        "viewport register read-back differs from the value written")

endmodule

bind vertex_perspective_transform vpt_checker u_vpt_checker (.*);
